FILE: rtl/assert_macros.svh
// Assertion helpers shared by the fader modules.
// Each module that uses them has signals named clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/cfspf_pkg.sv
package cfspf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int POSITION_BITS  = 48;
    localparam int FADE_BITS      = 16;
    localparam int FUNC_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = POSITION_BITS;
    localparam int PROD_BITS      = SAMPLE_BITS + FADE_BITS;
    localparam int CNT_BITS       = $clog2(SAMPLE_BITS);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FADE_BITS-1:0] FADE_RESET = FADE_BITS'(100);

    // Item kinds.
    localparam logic [FUNC_BITS-1:0] FUNC_SAMPLE = FUNC_BITS'(0);
    localparam logic [FUNC_BITS-1:0] FUNC_PAUSE  = FUNC_BITS'(1);
    localparam logic [FUNC_BITS-1:0] FUNC_SEEK   = FUNC_BITS'(2);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FADE_LENGTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_LENGTH = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_LIST    = CFG_INDEX_BITS'(2);

    typedef struct packed {
        logic [FADE_BITS-1:0]     fade_length;
        logic [POSITION_BITS-1:0] total_length;
        logic                     loop_list;
    } cfg_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                          scale;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [FADE_BITS-1:0]          num;
        logic                          frame_end;
        logic                          seek_valid;
        logic [POSITION_BITS-1:0]      seek_position;
        logic                          request_ok;
    } job_t;

endpackage

FILE: rtl/cfspf_front.sv
module cfspf_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [cfspf_pkg::FUNC_BITS-1:0]         func,
    input  logic signed [cfspf_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                    frame_end,
    input  logic                                    pause_on,
    input  logic [cfspf_pkg::POSITION_BITS-1:0]     target_position,
    input  logic                                    force_req,
    input  cfspf_pkg::cfg_t                         cfg,
    input  logic                                    q_full,
    output logic                                    push,
    output cfspf_pkg::job_t                         job
);

    logic [cfspf_pkg::FADE_BITS-1:0]     fdl_reg, fdl_next;
    logic [cfspf_pkg::FADE_BITS-1:0]     ful_reg, ful_next;
    logic                                paused_reg, paused_next;
    logic                                pending_reg, pending_next;
    logic [cfspf_pkg::POSITION_BITS-1:0] ptarget_reg, ptarget_next;

    logic [cfspf_pkg::POSITION_BITS-1:0] lim;
    logic [cfspf_pkg::POSITION_BITS-1:0] cmp_pos;
    logic [cfspf_pkg::POSITION_BITS-1:0] eff;
    logic                                pos_lt_total;
    logic                                total_nz;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // The seek limit is the last frame when looping, else the length itself.
    assign total_nz     = (cfg.total_length != '0);
    assign lim          = (cfg.loop_list && total_nz) ?
                          cfg.total_length - cfspf_pkg::POSITION_BITS'(1) : cfg.total_length;
    assign cmp_pos      = (func == cfspf_pkg::FUNC_SEEK) ? target_position : ptarget_reg;
    assign eff          = (cmp_pos < lim) ? cmp_pos : lim;
    assign pos_lt_total = (target_position < cfg.total_length);

    always_comb
    begin
        fdl_next     = fdl_reg;
        ful_next     = ful_reg;
        paused_next  = paused_reg;
        pending_next = pending_reg;
        ptarget_next = ptarget_reg;
        job          = '0;
        unique case (func)
            cfspf_pkg::FUNC_SAMPLE:
            begin
                job.frame_end = frame_end;
                job.sample    = sample_in;
                if (fdl_reg != '0)
                begin
                    job.scale = 1'b1;
                    job.num   = fdl_reg - cfspf_pkg::FADE_BITS'(1);
                    if (frame_end)
                    begin
                        fdl_next = fdl_reg - cfspf_pkg::FADE_BITS'(1);
                    end
                end
                else if (paused_reg)
                begin
                    job.sample = '0;
                end
                else if (pending_reg)
                begin
                    // The sample at the jump is dropped and the fade-up restarts.
                    job.sample        = '0;
                    job.seek_valid    = 1'b1;
                    job.seek_position = eff;
                    pending_next      = 1'b0;
                    ful_next          = cfg.fade_length;
                end
                else if (ful_reg != '0)
                begin
                    job.scale = 1'b1;
                    job.num   = (cfg.fade_length > ful_reg) ? cfg.fade_length - ful_reg : '0;
                    if (frame_end)
                    begin
                        ful_next = ful_reg - cfspf_pkg::FADE_BITS'(1);
                    end
                end
            end
            cfspf_pkg::FUNC_PAUSE:
            begin
                if (pause_on != paused_reg)
                begin
                    if (paused_reg)
                    begin
                        ful_next = cfg.fade_length;
                    end
                    else
                    begin
                        fdl_next = cfg.fade_length;
                    end
                    paused_next = pause_on;
                end
            end
            cfspf_pkg::FUNC_SEEK:
            begin
                if (total_nz)
                begin
                    if (force_req || paused_reg)
                    begin
                        fdl_next     = '0;
                        pending_next = 1'b0;
                        // A forced or paused seek at or past the end falls outside the playlist unless it loops.
                        if (cfg.loop_list || pos_lt_total)
                        begin
                            ful_next          = cfg.fade_length;
                            job.seek_valid    = 1'b1;
                            job.seek_position = eff;
                            job.request_ok    = 1'b1;
                        end
                    end
                    else
                    begin
                        fdl_next       = cfg.fade_length;
                        ptarget_next   = pos_lt_total ? target_position : cfg.total_length;
                        pending_next   = 1'b1;
                        job.request_ok = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdl_reg     <= '0;
            ful_reg     <= cfspf_pkg::FADE_RESET;
            paused_reg  <= 1'b0;
            pending_reg <= 1'b0;
            ptarget_reg <= '0;
        end
        else if (push)
        begin
            fdl_reg     <= fdl_next;
            ful_reg     <= ful_next;
            paused_reg  <= paused_next;
            pending_reg <= pending_next;
            ptarget_reg <= ptarget_next;
        end
    end

endmodule

FILE: rtl/cfspf_queue.sv
`include "assert_macros.svh"

module cfspf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfspf_pkg::job_t push_data,
    input  logic            pop,
    output cfspf_pkg::job_t pop_data,
    output logic            full,
    output logic            empty
);

    cfspf_pkg::job_t                  entry_reg [cfspf_pkg::QUEUE_DEPTH];
    logic [cfspf_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cfspf_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cfspf_pkg::QCNT_BITS-1:0]  count_reg, count_next;

    localparam logic [cfspf_pkg::QPTR_BITS-1:0] PTR_LAST =
        cfspf_pkg::QPTR_BITS'(cfspf_pkg::QUEUE_DEPTH - 1);
    localparam logic [cfspf_pkg::QCNT_BITS-1:0] CNT_FULL =
        cfspf_pkg::QCNT_BITS'(cfspf_pkg::QUEUE_DEPTH);

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + cfspf_pkg::QPTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + cfspf_pkg::QPTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + cfspf_pkg::QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - cfspf_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_queue_overflow, push && full && !pop, "item pushed into a full queue")
    `ASSERT_NEVER(a_queue_underflow, pop && empty, "item popped from an empty queue")

endmodule

FILE: rtl/cfspf_back.sv
`include "assert_macros.svh"

module cfspf_back (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [cfspf_pkg::FADE_BITS-1:0]          fade_length,
    input  logic                                     q_empty,
    input  cfspf_pkg::job_t                          q_data,
    output logic                                     pop,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [cfspf_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                     frame_end_out,
    output logic                                     seek_valid,
    output logic [cfspf_pkg::POSITION_BITS-1:0]      seek_position,
    output logic                                     request_ok
);

    localparam int S = cfspf_pkg::SAMPLE_BITS;
    localparam int F = cfspf_pkg::FADE_BITS;
    localparam int P = cfspf_pkg::PROD_BITS;

    localparam logic [S-1:0] HALF   = {1'b1, {(S-1){1'b0}}};
    localparam logic [S-1:0] MAXV   = {1'b0, {(S-1){1'b1}}};
    localparam logic [S-1:0] MINV   = {1'b1, {(S-1){1'b0}}};
    localparam logic [cfspf_pkg::CNT_BITS-1:0] CNT_LAST = cfspf_pkg::CNT_BITS'(S - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic                           fe_reg, fe_next;
    logic                           neg_reg, neg_next;
    logic [S-1:0]                   mag_reg, mag_next;
    logic [F-1:0]                   num_reg, num_next;
    logic [P-1:0]                   prod_reg, prod_next;
    logic [F-1:0]                   rem_reg, rem_next;
    logic [S-1:0]                   quo_reg, quo_next;
    logic                           sat_reg, sat_next;
    logic [cfspf_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;

    logic                           ov_reg, ov_next;
    logic signed [S-1:0]            so_reg, so_next;
    logic                           feo_reg, feo_next;
    logic                           sv_reg, sv_next;
    logic [cfspf_pkg::POSITION_BITS-1:0] sp_reg, sp_next;
    logic                           ok_reg, ok_next;

    logic                           out_free;
    logic [F:0]                     partial;
    logic                           ge;
    logic [F-1:0]                   hi;
    logic                           over;
    logic [S-1:0]                   result;

    assign out_free = !ov_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && !q_empty && (q_data.scale || out_free);

    // One restoring division step: bring down the next dividend bit.
    assign partial = {rem_reg, quo_reg[S-1]};
    assign ge      = (partial >= {1'b0, fade_length});
    assign hi      = prod_reg[P-1:S];

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign over   = sat_reg || (neg_reg ? (quo_reg > HALF) : (quo_reg >= HALF));
    assign result = over ? (neg_reg ? MINV : MAXV) : (neg_reg ? (~quo_reg + S'(1)) : quo_reg);

    always_comb
    begin
        state_next = state_reg;
        fe_next    = fe_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        num_next   = num_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sat_next   = sat_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        so_next    = so_reg;
        feo_next   = feo_reg;
        sv_next    = sv_reg;
        sp_next    = sp_reg;
        ok_next    = ok_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (q_data.scale)
                    begin
                        fe_next    = q_data.frame_end;
                        neg_next   = q_data.sample[S-1];
                        mag_next   = q_data.sample[S-1] ? (~q_data.sample + S'(1)) : q_data.sample;
                        num_next   = q_data.num;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        ov_next  = 1'b1;
                        so_next  = q_data.sample;
                        feo_next = q_data.frame_end;
                        sv_next  = q_data.seek_valid;
                        sp_next  = q_data.seek_position;
                        ok_next  = q_data.request_ok;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = P'(mag_reg) * P'(num_reg);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                sat_next = 1'b0;
                if (fade_length == '0)
                begin
                    quo_next   = '0;
                    state_next = ST_DONE;
                end
                else if (hi >= fade_length)
                begin
                    // The quotient would not fit the sample width.
                    sat_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = hi;
                    quo_next   = prod_reg[S-1:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? F'(partial - {1'b0, fade_length}) : partial[F-1:0];
                quo_next = {quo_reg[S-2:0], ge};
                cnt_next = cnt_reg + cfspf_pkg::CNT_BITS'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    so_next    = result;
                    feo_next   = fe_reg;
                    sv_next    = 1'b0;
                    sp_next    = '0;
                    ok_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fe_reg   <= fe_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        cnt_reg  <= cnt_next;
        so_reg   <= so_next;
        feo_reg  <= feo_next;
        sv_reg   <= sv_next;
        sp_reg   <= sp_next;
        ok_reg   <= ok_next;
    end

    assign out_valid     = ov_reg;
    assign sample_out    = so_reg;
    assign frame_end_out = feo_reg;
    assign seek_valid    = sv_reg;
    assign seek_position = sp_reg;
    assign request_ok    = ok_reg;

    `ASSERT_PROP(a_rem_below_divisor, (state_reg == ST_DIV) |-> (rem_reg < fade_length), "divider remainder not below fade length")
    `ASSERT_PROP(a_done_waits, (state_reg == ST_DONE && ov_reg && out_stall) |=> (state_reg == ST_DONE), "finished result dropped while output stalled")

endmodule

FILE: rtl/click_free_seek_and_pause_fader.sv
// Click-free seek and pause fader.
// Input channel (in_valid/in_stall) carries audio samples, pause controls and
// seek requests, selected by func. Output channel (out_valid/out_stall) returns
// exactly one item per input item, in order.
// The front classifies each item and updates the fade, pause and seek state in
// the cycle it is accepted; a two-entry queue hands the item to the back, which
// owns the output register and a bit-serial divider.
// Path: an unscaled item moves from the queue into the output register. A
// sample inside a fade ramp is multiplied, then divided by fade_length one
// quotient bit a cycle; it then waits until the output register is free.
// Throughput: one unscaled item per cycle while out_stall is low; the back
// takes no new item until a faded sample has left the 24-step divider.
// Configuration: cfg_we/cfg_index/cfg_data write fade_length, total_length and
// the playlist loop flag; write only while no items are in flight.
// Reset clears the queue and the output valid flag, and loads the fade-up
// counter and fade_length with 100 frames. While out_stall is high the output
// item holds, the back keeps one finished item waiting, and in_stall rises once
// the queue fills.
module click_free_seek_and_pause_fader (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [cfspf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [cfspf_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [cfspf_pkg::FUNC_BITS-1:0]          func,
    input  logic signed [cfspf_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                     frame_end,
    input  logic                                     pause_on,
    input  logic [cfspf_pkg::POSITION_BITS-1:0]      target_position,
    input  logic                                     force_req,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [cfspf_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                     frame_end_out,
    output logic                                     seek_valid,
    output logic [cfspf_pkg::POSITION_BITS-1:0]      seek_position,
    output logic                                     request_ok
);

    cfspf_pkg::cfg_t cfg_reg;
    cfspf_pkg::job_t push_data;
    cfspf_pkg::job_t pop_data;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_length  <= cfspf_pkg::FADE_RESET;
            cfg_reg.total_length <= '0;
            cfg_reg.loop_list    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cfspf_pkg::CFG_FADE_LENGTH:
                begin
                    cfg_reg.fade_length <= cfg_data[cfspf_pkg::FADE_BITS-1:0];
                end
                cfspf_pkg::CFG_TOTAL_LENGTH:
                begin
                    cfg_reg.total_length <= cfg_data[cfspf_pkg::POSITION_BITS-1:0];
                end
                cfspf_pkg::CFG_LOOP_LIST:
                begin
                    cfg_reg.loop_list <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    cfspf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .sample_in       (sample_in),
        .frame_end       (frame_end),
        .pause_on        (pause_on),
        .target_position (target_position),
        .force_req       (force_req),
        .cfg             (cfg_reg),
        .q_full          (q_full),
        .push            (push),
        .job             (push_data)
    );

    cfspf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    cfspf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fade_length   (cfg_reg.fade_length),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .frame_end_out (frame_end_out),
        .seek_valid    (seek_valid),
        .seek_position (seek_position),
        .request_ok    (request_ok)
    );

endmodule

FILE: bench/click_free_seek_and_pause_fader_test.sv
`timescale 1ns / 100ps

module click_free_seek_and_pause_fader_test;

    import cfspf_pkg::*;

    // Func code three is not a defined item kind; the block must leave its state alone and return an all-zero item.
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = FUNC_BITS'(3);
    localparam int ITEMS_PER_PHASE = 171;
    localparam int PHASES = 10;

    typedef struct packed {
        logic [FUNC_BITS-1:0]          kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          fend;
        logic                          pause_req;
        logic [POSITION_BITS-1:0]      target;
        logic                          force_seek;
    } fader_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          fend;
        logic                          seek;
        logic [POSITION_BITS-1:0]      position;
        logic                          ok;
    } fader_out_t;

    class fader_scoreboard;
        logic [FADE_BITS-1:0]     fade_len;
        logic [POSITION_BITS-1:0] total_len;
        logic                     loop_on;
        logic [FADE_BITS-1:0]     down_left;
        logic [FADE_BITS-1:0]     up_left;
        logic                     paused;
        logic                     seek_waiting;
        logic [POSITION_BITS-1:0] seek_target;
        fader_out_t               due_outputs[$];
        int                       mismatches;

        function new();
            fade_len = FADE_RESET;
            total_len = '0;
            loop_on = 1'b0;
            down_left = '0;
            up_left = FADE_RESET;
            paused = 1'b0;
            seek_waiting = 1'b0;
            seek_target = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
            case (index)
                CFG_FADE_LENGTH:  fade_len = data[FADE_BITS-1:0];
                CFG_TOTAL_LENGTH: total_len = data[POSITION_BITS-1:0];
                CFG_LOOP_LIST:    loop_on = data[0];
                default: ;
            endcase
        endfunction

        // Multiply, divide by the fade length truncating toward zero, saturate.
        function logic signed [SAMPLE_BITS-1:0] gain(logic signed [SAMPLE_BITS-1:0] s,
                                                     logic [FADE_BITS-1:0] num);
            longint v;
            longint top;
            top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            if (fade_len == 0)
                return '0;
            v = longint'(s) * longint'(num) / longint'(fade_len);
            if (v > top)
                v = top;
            if (v < -top - 1)
                v = -top - 1;
            return v[SAMPLE_BITS-1:0];
        endfunction

        function logic [POSITION_BITS-1:0] seek_clamp(logic [POSITION_BITS-1:0] pos);
            logic [POSITION_BITS-1:0] lim;
            lim = total_len;
            if (loop_on && lim != 0)
                lim = lim - 1'b1;
            return (pos < lim) ? pos : lim;
        endfunction

        function void predict_item(fader_item_t it);
            fader_out_t r;
            logic [POSITION_BITS-1:0] pos;
            logic [POSITION_BITS-1:0] eff;
            r = '0;
            case (it.kind)
                FUNC_SAMPLE:
                begin
                    r.fend = it.fend;
                    if (down_left != 0)
                    begin
                        r.sample = gain(it.sample, down_left - 1'b1);
                        if (it.fend)
                            down_left = down_left - 1'b1;
                    end
                    else if (paused)
                        r.sample = '0;
                    else if (seek_waiting)
                    begin
                        r.seek = 1'b1;
                        r.position = seek_clamp(seek_target);
                        seek_waiting = 1'b0;
                        up_left = fade_len;
                    end
                    else if (up_left != 0)
                    begin
                        r.sample = gain(it.sample,
                                        (fade_len > up_left) ? fade_len - up_left
                                                             : FADE_BITS'(0));
                        if (it.fend)
                            up_left = up_left - 1'b1;
                    end
                    else
                        r.sample = it.sample;
                end
                FUNC_PAUSE:
                begin
                    if (it.pause_req != paused)
                    begin
                        if (paused)
                            up_left = fade_len;
                        else
                            down_left = fade_len;
                        paused = it.pause_req;
                    end
                end
                FUNC_SEEK:
                begin
                    pos = (it.target > total_len) ? total_len : it.target;
                    if (total_len != 0)
                    begin
                        if (it.force_seek || paused)
                        begin
                            eff = seek_clamp(pos);
                            down_left = '0;
                            seek_waiting = 1'b0;
                            // A forced or paused jump to the very end is refused.
                            if (eff < total_len)
                            begin
                                up_left = fade_len;
                                r.seek = 1'b1;
                                r.position = eff;
                                r.ok = 1'b1;
                            end
                        end
                        else
                        begin
                            down_left = fade_len;
                            seek_target = pos;
                            seek_waiting = 1'b1;
                            r.ok = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            due_outputs = {due_outputs, r};
        endfunction

        function void check_output(fader_out_t got);
            fader_out_t want;
            if (due_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none due: sample %0d fe %0b seek %0b pos %0d ok %0b",
                             $realtime, got.sample, got.fend, got.seek, got.position, got.ok);
                return;
            end
            want = due_outputs.pop_front();
            if (got.sample !== want.sample || got.fend !== want.fend || got.seek !== want.seek
                || got.position !== want.position || got.ok !== want.ok)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: expected sample %0d fe %0b seek %0b pos %0d ok %0b",
                             $realtime, want.sample, want.fend, want.seek, want.position,
                             want.ok);
                    $display("%0t:      got sample %0d fe %0b seek %0b pos %0d ok %0b",
                             $realtime, got.sample, got.fend, got.seek, got.position, got.ok);
                end
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]       cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]        cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [FUNC_BITS-1:0]            func = '0;
    logic signed [SAMPLE_BITS-1:0]   sample_in = '0;
    logic                            frame_end = 1'b0;
    logic                            pause_on = 1'b0;
    logic [POSITION_BITS-1:0]        target_position = '0;
    logic                            force_req = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0]   sample_out;
    logic                            frame_end_out;
    logic                            seek_valid;
    logic [POSITION_BITS-1:0]        seek_position;
    logic                            request_ok;

    fader_scoreboard fader_model;
    logic            quiet = 1'b0;

    click_free_seek_and_pause_fader dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .sample_in       (sample_in),
        .frame_end       (frame_end),
        .pause_on        (pause_on),
        .target_position (target_position),
        .force_req       (force_req),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_out      (sample_out),
        .frame_end_out   (frame_end_out),
        .seek_valid      (seek_valid),
        .seek_position   (seek_position),
        .request_ok      (request_ok)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            fader_model.check_output(fader_out_t'{sample_out, frame_end_out, seek_valid,
                                                  seek_position, request_ok});
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 14);
    end

    function automatic fader_item_t make_item(logic [FUNC_BITS-1:0] kind,
                                              logic signed [SAMPLE_BITS-1:0] sample,
                                              logic fend, logic pause_req,
                                              logic [POSITION_BITS-1:0] target,
                                              logic force_seek);
        fader_item_t it;
        it.kind = kind;
        it.sample = sample;
        it.fend = fend;
        it.pause_req = pause_req;
        it.target = target;
        it.force_seek = force_seek;
        return it;
    endfunction

    // Mostly samples; pause requests, unused kinds and seeks often at or past the end.
    function automatic fader_item_t random_item(logic [POSITION_BITS-1:0] total_len);
        fader_item_t it;
        int pick;
        it.sample = SAMPLE_BITS'($urandom);
        it.fend = 1'($urandom);
        it.pause_req = 1'($urandom);
        it.target = POSITION_BITS'({$urandom, $urandom});
        it.force_seek = ($urandom_range(99) < 40);
        pick = $urandom_range(99);
        if (pick < 72)
        begin
            it.kind = FUNC_SAMPLE;
            if ($urandom_range(9) == 0)
                it.sample = $urandom_range(1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                              : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else if (pick < 82)
            it.kind = FUNC_PAUSE;
        else if (pick < 97)
        begin
            it.kind = FUNC_SEEK;
            case ($urandom_range(3))
                0: it.target = total_len;
                1: it.target = total_len + POSITION_BITS'($urandom_range(3));
                default:
                    if (total_len != 0)
                        it.target = it.target % total_len;
            endcase
        end
        else
            it.kind = FUNC_UNUSED;
        return it;
    endfunction

    task automatic send_item(fader_item_t it);
        while (!quiet && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func <= it.kind;
        sample_in <= it.sample;
        frame_end <= it.fend;
        pause_on <= it.pause_req;
        target_position <= it.target;
        force_req <= it.force_seek;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fader_model.predict_item(it);
    endtask

    // Registers change only once every item in flight has come back.
    task automatic configure(logic [FADE_BITS-1:0] fade_len,
                             logic [POSITION_BITS-1:0] total_len, logic loop_on);
        logic [CFG_DATA_BITS-1:0] values[3];
        logic [CFG_INDEX_BITS-1:0] regs[3];
        values[0] = CFG_DATA_BITS'(fade_len);
        values[1] = CFG_DATA_BITS'(total_len);
        values[2] = CFG_DATA_BITS'(loop_on);
        regs[0] = CFG_FADE_LENGTH;
        regs[1] = CFG_TOTAL_LENGTH;
        regs[2] = CFG_LOOP_LIST;
        in_valid <= 1'b0;
        while (fader_model.due_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= values[i];
            @(posedge clk);
            fader_model.write_reg(regs[i], values[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        fader_item_t it;
        int counted;
        logic [SAMPLE_BITS-1:0] ones;
        ones = '1;
        fader_model = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty playlist, fade-up from reset still running.
        send_item(make_item(FUNC_SAMPLE, 24'sd8388607, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SAMPLE, -24'sd8388608, 1'b0, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SEEK, '0, 1'b0, 1'b0, 48'd5, 1'b0));
        send_item(make_item(FUNC_SEEK, '0, 1'b0, 1'b0, '1, 1'b1));
        send_item(make_item(FUNC_UNUSED, ones, 1'b1, 1'b1, '1, 1'b1));
        send_item(make_item(FUNC_PAUSE, '0, 1'b0, 1'b0, '0, 1'b0));

        // Short fades; the leftover fade-up count now exceeds the fade length.
        configure(16'd2, 48'd10, 1'b0);
        send_item(make_item(FUNC_SAMPLE, 24'sd1000, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SEEK, '0, 1'b0, 1'b0, 48'd20, 1'b1));
        send_item(make_item(FUNC_SAMPLE, 24'sd8388607, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SEEK, '0, 1'b0, 1'b0, 48'd3, 1'b1));
        send_item(make_item(FUNC_SAMPLE, -24'sd8388608, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SAMPLE, 24'sd8388607, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SAMPLE, 24'sd12345, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SEEK, '0, 1'b0, 1'b0, 48'd7, 1'b0));
        send_item(make_item(FUNC_SAMPLE, -24'sd7, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SAMPLE, 24'sd8388607, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SAMPLE, 24'sd100, 1'b0, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_PAUSE, '0, 1'b0, 1'b1, '0, 1'b0));
        send_item(make_item(FUNC_PAUSE, '0, 1'b0, 1'b1, '0, 1'b0));
        send_item(make_item(FUNC_SAMPLE, -24'sd8388608, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SEEK, '0, 1'b0, 1'b0, 48'd4, 1'b0));
        send_item(make_item(FUNC_PAUSE, '0, 1'b0, 1'b0, '0, 1'b0));

        // Zero fade length mutes scaled samples; looping allows a jump to the last frame.
        configure(16'd0, 48'd10, 1'b1);
        send_item(make_item(FUNC_SAMPLE, 24'sd8388607, 1'b1, 1'b0, '0, 1'b0));
        send_item(make_item(FUNC_SEEK, '0, 1'b0, 1'b0, '1, 1'b1));
        send_item(make_item(FUNC_SAMPLE, 24'sd77, 1'b1, 1'b0, '0, 1'b0));

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: configure(16'd4, 48'd1000, 1'b0);
                1: configure(16'd1, 48'd1, 1'b0);
                2: configure(16'd7, 48'd1, 1'b1);
                3: configure(16'd0, 48'd500, 1'b0);
                4: configure(16'd3, '1, 1'b1);
                5: configure(16'hFFFF, POSITION_BITS'({$urandom, $urandom}) | 48'd1, 1'b0);
                6: configure(FADE_BITS'($urandom_range(12, 1)),
                             POSITION_BITS'({$urandom, $urandom}) | 48'd1, 1'b1);
                7: configure(16'd2, 48'd37, 1'b1);
                8: configure(16'd5, POSITION_BITS'($urandom_range(5000, 2)), 1'b0);
                default: configure(16'd6, 48'd12, 1'b0);
            endcase
            quiet = (p == 4 || p == 5);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                it = random_item(fader_model.total_len);
                send_item(it);
                if (it.kind != FUNC_UNUSED
                    && !(it.kind == FUNC_SEEK && fader_model.total_len == 0))
                    counted++;
            end
            // Leave a fade-down of this phase's length running into the next setting.
            send_item(make_item(FUNC_PAUSE, '0, 1'b0, 1'b0, '0, 1'b0));
            send_item(make_item(FUNC_PAUSE, '0, 1'b0, 1'b1, '0, 1'b0));
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (fader_model.due_outputs.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fader_model.mismatches == 0 && fader_model.due_outputs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
